[rtl/ihe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Ising Hamiltonian element block.
// No dependencies; used by every module under rtl/.
package ihe_pkg;

    localparam int IDX_W          = 16;  // row/column index width
    localparam int SIDE_W         = 3;   // lattice side register width
    localparam int COEF_W         = 16;  // Q8.8 coefficient width
    localparam int VAL_W          = 22;  // Q14.8 element width
    localparam int SUM_W          = 6;   // signed bond/spin sum width
    localparam int MAX_SIDE_LIMIT = 4;
    localparam int MAX_SIDE_DEF   = 4;

    // Kind of matrix element, settled in the first stage.
    typedef enum logic [1:0] {
        CLS_ZERO  = 2'd0,
        CLS_DIAG  = 2'd1,
        CLS_FLIP  = 2'd2,
        CLS_RANGE = 2'd3
    } t_class;

    // Payload handed from the decode stage to the scaling stage.
    typedef struct packed {
        t_class                   cls;
        logic signed [SUM_W-1:0]  bond_sum;
        logic signed [SUM_W-1:0]  spin_sum;
    } t_s1;

endpackage

[rtl/ihe_front.sv]
`timescale 1ns / 1ps
// Decode stage: index range check, element class, bond and spin sums.
// Depends on ihe_pkg.
module ihe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ihe_pkg::SIDE_W-1:0]     i_side,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ihe_pkg::IDX_W-1:0]      i_row_index,
    input  logic [ihe_pkg::IDX_W-1:0]      i_col_index,
    output logic                           o_s1_valid,
    input  logic                           i_s1_ready,
    output ihe_pkg::t_s1                   o_s1
);

    localparam int IW = ihe_pkg::IDX_W;

    // popcount of 16 bits as four nibble counts and a short sum
    function automatic logic [4:0] pop16(input logic [IW-1:0] v);
        logic [2:0] nib [4];
        logic [4:0] tot;
        tot = '0;
        for (int i = 0; i < 4; i++) begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        tot = 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
        return tot;
    endfunction

    logic                          r_valid;
    ihe_pkg::t_s1                  r_s1;
    ihe_pkg::t_s1                  n_s1;

    logic [4:0]                    n_spins;
    logic [4:0]                    n_bonds;
    logic [IW-1:0]                 low_mask;
    logic [IW-1:0]                 h_mask;
    logic [IW-1:0]                 v_mask;
    logic [IW-1:0]                 pos;
    logic [IW-1:0]                 h_mis;
    logic [IW-1:0]                 v_mis;
    logic [4:0]                    mism;
    logic [4:0]                    ones;
    logic [IW-1:0]                 diff;
    logic                          out_of_range;

    // Lattice geometry per side; position p holds index bit n-1-p.
    always_comb begin
        unique case (i_side)
            3'd2: begin
                n_spins = 5'd4;   n_bonds = 5'd4;
                low_mask = 16'h000F; h_mask = 16'h0005; v_mask = 16'h0003;
            end
            3'd3: begin
                n_spins = 5'd9;   n_bonds = 5'd12;
                low_mask = 16'h01FF; h_mask = 16'h00DB; v_mask = 16'h003F;
            end
            3'd4: begin
                n_spins = 5'd16;  n_bonds = 5'd24;
                low_mask = 16'hFFFF; h_mask = 16'h7777; v_mask = 16'h0FFF;
            end
            default: begin
                n_spins = 5'd1;   n_bonds = 5'd0;
                low_mask = 16'h0001; h_mask = 16'h0000; v_mask = 16'h0000;
            end
        endcase
    end

    always_comb begin
        for (int p = 0; p < IW; p++) begin
            pos[p] = (5'(p) < n_spins) ? i_row_index[4'(n_spins - 5'(p) - 5'd1)] : 1'b0;
        end
        h_mis = h_mask & (pos ^ (pos >> 1));
        v_mis = v_mask & (pos ^ (pos >> i_side));
        mism  = pop16(h_mis) + pop16(v_mis);
        ones  = pop16(pos);

        diff         = i_row_index ^ i_col_index;
        out_of_range = (|(i_row_index & ~low_mask)) || (|(i_col_index & ~low_mask));

        priority if (out_of_range) begin
            n_s1.cls = ihe_pkg::CLS_RANGE;
        end else if (diff == '0) begin
            n_s1.cls = ihe_pkg::CLS_DIAG;
        end else if ((diff & (diff - 16'd1)) == '0) begin
            n_s1.cls = ihe_pkg::CLS_FLIP;
        end else begin
            n_s1.cls = ihe_pkg::CLS_ZERO;
        end
        // matched bonds count +1, mismatched -1; spin 0 counts +1, spin 1 -1
        n_s1.bond_sum = $signed(6'(n_bonds) - {mism, 1'b0});
        n_s1.spin_sum = $signed(6'(n_spins) - {ones, 1'b0});
    end

    assign o_ready    = !r_valid || i_s1_ready;
    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_s1 <= n_s1;
        end
    end

endmodule

[rtl/ihe_back.sv]
`timescale 1ns / 1ps
// Scaling stage: applies J, Bz and Bx to the decoded sums into the result register.
// Depends on ihe_pkg.
module ihe_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s1_valid,
    output logic                                  o_s1_ready,
    input  ihe_pkg::t_s1                          i_s1,
    input  logic signed [ihe_pkg::COEF_W-1:0]     i_coupling,
    input  logic signed [ihe_pkg::COEF_W-1:0]     i_field_x,
    input  logic signed [ihe_pkg::COEF_W-1:0]     i_field_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ihe_pkg::VAL_W-1:0]      o_element_value,
    output logic                                  o_index_out_of_range
);

    localparam int VW = ihe_pkg::VAL_W;

    logic                   r_valid;
    logic signed [VW-1:0]   r_value;
    logic                   r_flag;
    logic signed [VW-1:0]   prod_j;
    logic signed [VW-1:0]   prod_z;
    logic signed [VW-1:0]   n_value;
    logic                   n_flag;

    // both products fit in 22 bits exactly, so truncation loses nothing
    assign prod_j = VW'(i_coupling) * VW'(i_s1.bond_sum);
    assign prod_z = VW'(i_field_z) * VW'(i_s1.spin_sum);

    always_comb begin
        n_flag = 1'b0;
        unique case (i_s1.cls)
            ihe_pkg::CLS_DIAG:  n_value = prod_j - prod_z;
            ihe_pkg::CLS_FLIP:  n_value = -VW'(i_field_x);
            ihe_pkg::CLS_RANGE: begin
                n_value = '0;
                n_flag  = 1'b1;
            end
            default:            n_value = '0;
        endcase
    end

    assign o_s1_ready           = !r_valid || i_ready;
    assign o_valid              = r_valid;
    assign o_element_value      = r_value;
    assign o_index_out_of_range = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_valid <= i_s1_valid;
        end
        if (i_s1_valid && o_s1_ready) begin
            r_value <= n_value;
            r_flag  <= n_flag;
        end
    end

endmodule

[rtl/ising_hamiltonian_element.sv]
`timescale 1ns / 1ps
// An accepted item passes through the decode register and then the result register (decode, then scale).
// Throughput: one item per cycle while i_ready is high; under back-pressure each full pipeline register holds its item.
// The 16x6 multipliers in the scaling stage are combinational; nothing iterates.
// Reset (synchronous, i_rst_n low): pipeline emptied, side 2, J = 1.0, Bx = Bz = 0.
// Depends on ihe_pkg, ihe_front and ihe_back.
module ising_hamiltonian_element #(
    parameter int MAX_SIDE = ihe_pkg::MAX_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // element requests
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [ihe_pkg::IDX_W-1:0]             i_row_index,
    input  logic [ihe_pkg::IDX_W-1:0]             i_col_index,
    // element results
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ihe_pkg::VAL_W-1:0]      o_element_value,
    output logic                                  o_index_out_of_range
);

    // register map, word addressed through paddr[3:2]
    localparam logic [1:0] REG_SIDE     = 2'd0;
    localparam logic [1:0] REG_COUPLING = 2'd1;
    localparam logic [1:0] REG_FIELD_X  = 2'd2;
    localparam logic [1:0] REG_FIELD_Z  = 2'd3;

    localparam int SW = ihe_pkg::SIDE_W;
    localparam int CW = ihe_pkg::COEF_W;

    logic [SW-1:0]          r_lattice_side;
    logic signed [CW-1:0]   r_coupling;
    logic signed [CW-1:0]   r_field_x;
    logic signed [CW-1:0]   r_field_z;
    logic                   cfg_wr;
    logic [SW-1:0]          side_eff;
    logic                   s1_valid;
    logic                   s1_ready;
    ihe_pkg::t_s1           s1;

    // ---------------------------------------------------------------------
    // Configuration registers. A write lands in the access phase; pready
    // is tied high so every transfer completes without wait states.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice_side <= 3'd2;
            r_coupling     <= 16'sd256;
            r_field_x      <= '0;
            r_field_z      <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SIDE:     r_lattice_side <= pwdata[SW-1:0];
                REG_COUPLING: r_coupling     <= pwdata[CW-1:0];
                REG_FIELD_X:  r_field_x      <= pwdata[CW-1:0];
                REG_FIELD_Z:  r_field_z      <= pwdata[CW-1:0];
                default:      ;
            endcase
        end
    end

    // read back the raw register bits, zero-extended
    always_comb begin
        unique case (paddr[3:2])
            REG_SIDE:     prdata = 32'(r_lattice_side);
            REG_COUPLING: prdata = 32'(unsigned'(r_coupling));
            REG_FIELD_X:  prdata = 32'(unsigned'(r_field_x));
            REG_FIELD_Z:  prdata = 32'(unsigned'(r_field_z));
            default:      prdata = '0;
        endcase
    end

    // Clamp the side: zero behaves as one, anything above MAX_SIDE as MAX_SIDE.
    always_comb begin
        priority if (r_lattice_side == '0) begin
            side_eff = SW'(1);
        end else if (r_lattice_side > SW'(MAX_SIDE)) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = r_lattice_side;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: decode the index pair into an element class and the
    // bond/spin sums of the row's basis state.
    // ---------------------------------------------------------------------
    ihe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (side_eff),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1        (s1)
    );

    // ---------------------------------------------------------------------
    // Stage 2: scale by J, Bz or Bx and hold the item in the result
    // register until the consumer takes it.
    // ---------------------------------------------------------------------
    ihe_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_s1_valid           (s1_valid),
        .o_s1_ready           (s1_ready),
        .i_s1                 (s1),
        .i_coupling           (r_coupling),
        .i_field_x            (r_field_x),
        .i_field_z            (r_field_z),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_element_value      (o_element_value),
        .o_index_out_of_range (o_index_out_of_range)
    );

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // an out-of-range result always carries a zero element
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_out_of_range |-> o_element_value == '0)
        else $error("out-of-range item with non-zero element");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a side write takes effect on the next edge
    a_side_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && paddr[3:2] == REG_SIDE |=> r_lattice_side == $past(pwdata[SW-1:0]))
        else $error("lattice side write lost");

    // the effective side never leaves 1..MAX_SIDE
    a_side_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        side_eff != '0 && side_eff <= SW'(MAX_SIDE))
        else $error("effective side out of range");

endmodule
